>>> design/sre_pkg.sv
package sre_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] SYM_I     = 8'h69;
	localparam logic [7:0] SYM_D     = 8'h64;
	localparam logic [7:0] SYM_E     = 8'h45;
	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_STAR  = 8'h2A;
	localparam logic [7:0] SYM_OPEN  = 8'h28;
	localparam logic [7:0] SYM_CLOSE = 8'h29;
	localparam logic [7:0] SYM_SPACE = 8'h20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_CHECK,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic shift;
		logic reduce;
		logic rd_en;
		logic rd_sel;   // 0: second from top, 1: third from top
		logic cap_t1;
		logic cap_t2;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic             space;
		logic             match;
		logic             out_free;
		logic             ovf;
		logic [CNT_W-1:0] count;
	} sts_t;

endpackage

>>> design/shift_reduce_expression_recognizer.sv
// A request passes through IDLE, SHIFT, CHECK and RESULT for a character that
// causes no reduction, and IDLE, SHIFT and RESULT for a space; each reduction
// adds a match check plus two registered reads of the stack memory to refill
// the top-of-stack cache. One request is in progress at a time; the next one
// is taken once the result is in the output register, which RESULT waits for
// while the output is stalled. Reset (arst_n low) empties the stack, clears overflow.
module shift_reduce_expression_recognizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // depth[7:0], top_symbol[15:8], accepted[16], overflow[17]
);

	sre_pkg::cmd_t cmd;
	sre_pkg::sts_t sts;

	sre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	sre_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	a_acc_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> m_tdata[7:0] == 8'd1)
		else $error("accepted flagged with depth other than one");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("new request taken while one is in progress");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sts.ovf |=> sts.ovf)
		else $error("overflow flag cleared");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= sre_pkg::CNT_W'(sre_pkg::STACK_DEPTH))
		else $error("stack count beyond depth");

endmodule

>>> design/sre_ctrl.sv
module sre_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output sre_pkg::cmd_t   cmd,
	input  sre_pkg::sts_t   sts
);

	sre_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sre_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			sre_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = sre_pkg::ST_SHIFT;
				end
			end
			sre_pkg::ST_SHIFT: begin
				if (sts.space) begin
					state_d = sre_pkg::ST_RESULT;
				end else begin
					cmd.shift = 1'b1;
					state_d   = sre_pkg::ST_CHECK;
				end
			end
			sre_pkg::ST_CHECK: begin
				if (sts.match) begin
					cmd.reduce = 1'b1;
					state_d    = sre_pkg::ST_RD1;
				end else begin
					state_d = sre_pkg::ST_RESULT;
				end
			end
			sre_pkg::ST_RD1: begin
				cmd.rd_en = 1'b1;
				state_d   = sre_pkg::ST_RD2;
			end
			sre_pkg::ST_RD2: begin
				cmd.cap_t1 = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = 1'b1;
				state_d    = sre_pkg::ST_RD3;
			end
			sre_pkg::ST_RD3: begin
				cmd.cap_t2 = 1'b1;
				state_d    = sre_pkg::ST_CHECK;
			end
			sre_pkg::ST_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sre_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sre_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/sre_dp.sv
module sre_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      s_tdata,   // ch
	input  logic            s_tlast,   // end_of_string
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [23:0]     m_tdata,   // depth[7:0], top_symbol[15:8], accepted[16], overflow[17]
	input  sre_pkg::cmd_t   cmd,
	output sre_pkg::sts_t   sts
);

	logic [7:0]                  mem [sre_pkg::STACK_DEPTH];
	logic [7:0]                  rd_q;

	logic [sre_pkg::CNT_W-1:0]   count_q;
	logic                        ovf_q;
	logic                        m_tvalid_q;

	logic [7:0]                  ch_q;
	logic                        eos_q;
	// top three stack symbols, meaningful only below count_q
	logic [7:0]                  t0_q, t1_q, t2_q;
	logic [23:0]                 m_tdata_q;

	logic                        id_hit, tri_hit, full;
	logic [sre_pkg::CNT_W-1:0]   new_count;
	logic [sre_pkg::CNT_W-1:0]   rd_cnt;
	logic                        mem_we;
	logic [sre_pkg::IDX_W-1:0]   mem_wa;
	logic [7:0]                  mem_wd;
	logic [7:0]                  top_sym;
	logic                        acc;

	assign full = (count_q == sre_pkg::CNT_W'(sre_pkg::STACK_DEPTH));

	assign id_hit = (count_q >= sre_pkg::CNT_W'(2)) &&
		(t1_q == sre_pkg::SYM_I) && (t0_q == sre_pkg::SYM_D);

	assign tri_hit = (count_q >= sre_pkg::CNT_W'(3)) && (
		(t2_q == sre_pkg::SYM_E && t1_q == sre_pkg::SYM_PLUS && t0_q == sre_pkg::SYM_E) ||
		(t2_q == sre_pkg::SYM_E && t1_q == sre_pkg::SYM_STAR && t0_q == sre_pkg::SYM_E) ||
		(t2_q == sre_pkg::SYM_OPEN && t1_q == sre_pkg::SYM_E && t0_q == sre_pkg::SYM_CLOSE));

	// stack is kept fully reduced, so any new match ends at the top
	assign new_count = count_q - (tri_hit ? sre_pkg::CNT_W'(2) : sre_pkg::CNT_W'(1));

	always_comb begin
		mem_we = 1'b0;
		mem_wa = count_q[sre_pkg::IDX_W-1:0];
		mem_wd = ch_q;
		if (cmd.shift && !full) begin
			mem_we = 1'b1;
		end else if (cmd.reduce) begin
			mem_we = 1'b1;
			mem_wa = sre_pkg::IDX_W'(new_count - sre_pkg::CNT_W'(1));
			mem_wd = sre_pkg::SYM_E;
		end
	end

	assign rd_cnt = count_q - (cmd.rd_sel ? sre_pkg::CNT_W'(3) : sre_pkg::CNT_W'(2));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_cnt[sre_pkg::IDX_W-1:0]];
		end
	end

	assign top_sym = (count_q != '0) ? t0_q : 8'h00;
	assign acc     = (count_q == sre_pkg::CNT_W'(1)) && (t0_q == sre_pkg::SYM_E);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.shift) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + sre_pkg::CNT_W'(1);
				end
			end else if (cmd.reduce) begin
				count_q <= new_count;
			end else if (cmd.emit && eos_q) begin
				count_q <= '0;
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ch_q  <= s_tdata;
			eos_q <= s_tlast;
		end
		if (cmd.shift && !full) begin
			t0_q <= ch_q;
			t1_q <= t0_q;
			t2_q <= t1_q;
		end else if (cmd.reduce) begin
			t0_q <= sre_pkg::SYM_E;
		end
		if (cmd.cap_t1) begin
			t1_q <= rd_q;
		end
		if (cmd.cap_t2) begin
			t2_q <= rd_q;
		end
		if (cmd.emit) begin
			m_tdata_q <= {6'd0, ovf_q, acc, top_sym, 8'(count_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign sts.space    = (ch_q == sre_pkg::SYM_SPACE);
	assign sts.match    = id_hit || tri_hit;
	assign sts.out_free = !m_tvalid_q || m_tready;
	assign sts.ovf      = ovf_q;
	assign sts.count    = count_q;

endmodule

>>> dv/shift_reduce_expression_recognizer_tb.sv
`timescale 1ns / 100ps

module shift_reduce_expression_recognizer_tb;

	localparam int RAND_CHARS   = 1000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic [7:0] depth;
		logic [7:0] top_symbol;
		logic       accepted;
		logic       overflow;
	} parse_status_t;

	// Tracks the symbol stack as the block should see it and checks each status.
	class stack_predictor;
		logic [7:0]    stk [sre_pkg::STACK_DEPTH];
		int            cnt;
		bit            ovf;
		parse_status_t status_q [$];
		int            errors;
		int            n_req;
		int            n_res;
		int            n_accepted;
		int            max_depth;

		function new();
			cnt        = 0;
			ovf        = 0;
			errors     = 0;
			n_req      = 0;
			n_res      = 0;
			n_accepted = 0;
			max_depth  = 0;
			foreach (stk[i]) stk[i] = '0;
		endfunction

		function void collapse(int pos, int len);
			stk[pos] = sre_pkg::SYM_E;
			for (int m = pos + 1; m + len - 1 < cnt; m++)
				stk[m] = stk[m + len - 1];
			cnt -= len - 1;
		endfunction

		function bit fold_triple(logic [7:0] a, logic [7:0] b, logic [7:0] c);
			for (int k = 0; k + 2 < cnt; k++) begin
				if (stk[k] == a && stk[k+1] == b && stk[k+2] == c) begin
					collapse(k, 3);
					return 1;
				end
			end
			return 0;
		endfunction

		// One reduction in rule priority order, lowest position first.
		function bit reduce_pass();
			for (int k = 0; k + 1 < cnt; k++) begin
				if (stk[k] == sre_pkg::SYM_I && stk[k+1] == sre_pkg::SYM_D) begin
					collapse(k, 2);
					return 1;
				end
			end
			if (fold_triple(sre_pkg::SYM_E, sre_pkg::SYM_PLUS, sre_pkg::SYM_E))
				return 1;
			if (fold_triple(sre_pkg::SYM_E, sre_pkg::SYM_STAR, sre_pkg::SYM_E))
				return 1;
			return fold_triple(sre_pkg::SYM_OPEN, sre_pkg::SYM_E, sre_pkg::SYM_CLOSE);
		endfunction

		function void note_request(logic [7:0] ch, logic last);
			parse_status_t st;
			n_req++;
			if (ch != sre_pkg::SYM_SPACE) begin
				if (cnt < sre_pkg::STACK_DEPTH) begin
					stk[cnt] = ch;
					cnt++;
				end else begin
					ovf = 1;
				end
				while (reduce_pass()) begin
				end
			end
			st.depth      = cnt[7:0];
			st.top_symbol = (cnt > 0) ? stk[cnt-1] : 8'h00;
			st.accepted   = (cnt == 1 && stk[0] == sre_pkg::SYM_E);
			st.overflow   = ovf;
			status_q.push_back(st);
			if (cnt > max_depth)
				max_depth = cnt;
			if (last)
				cnt = 0;
		endfunction

		function void check_status(logic [23:0] d);
			parse_status_t exp_st;
			n_res++;
			if (status_q.size() == 0) begin
				$error("unexpected result 0x%06h with no request pending", d);
				errors++;
				return;
			end
			exp_st = status_q.pop_front();
			if (d[16])
				n_accepted++;
			if (d[7:0] !== exp_st.depth) begin
				$error("depth: expected %0d, got %0d", exp_st.depth, d[7:0]);
				errors++;
			end
			if (d[15:8] !== exp_st.top_symbol) begin
				$error("top_symbol: expected 0x%02h, got 0x%02h",
					exp_st.top_symbol, d[15:8]);
				errors++;
			end
			if (d[16] !== exp_st.accepted) begin
				$error("accepted: expected %0b, got %0b", exp_st.accepted, d[16]);
				errors++;
			end
			if (d[17] !== exp_st.overflow) begin
				$error("overflow: expected %0b, got %0b", exp_st.overflow, d[17]);
				errors++;
			end
		endfunction

		function int pending();
			return status_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	stack_predictor sb = new();
	logic [7:0]     expr_chars [$];
	bit             no_idle;
	bit             hold_done;
	int             n_sent;

	shift_reduce_expression_recognizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly zero or short, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void maybe_space();
		if ($urandom_range(0, 7) == 0)
			expr_chars.push_back(sre_pkg::SYM_SPACE);
	endfunction

	// Appends a random well-formed expression to expr_chars.
	function automatic void gen_expr(int lvl);
		int pick;
		pick = (lvl > 0) ? $urandom_range(0, 3) : 0;
		case (pick)
			0: begin
				expr_chars.push_back(sre_pkg::SYM_I);
				maybe_space();
				expr_chars.push_back(sre_pkg::SYM_D);
			end
			1, 2: begin
				gen_expr(lvl - 1);
				maybe_space();
				expr_chars.push_back(pick == 1 ? sre_pkg::SYM_PLUS : sre_pkg::SYM_STAR);
				maybe_space();
				gen_expr(lvl - 1);
			end
			default: begin
				expr_chars.push_back(sre_pkg::SYM_OPEN);
				maybe_space();
				gen_expr(lvl - 1);
				maybe_space();
				expr_chars.push_back(sre_pkg::SYM_CLOSE);
			end
		endcase
	endfunction

	function automatic logic [7:0] token_char();
		case ($urandom_range(0, 7))
			0: return sre_pkg::SYM_I;
			1: return sre_pkg::SYM_D;
			2: return sre_pkg::SYM_E;
			3: return sre_pkg::SYM_PLUS;
			4: return sre_pkg::SYM_STAR;
			5: return sre_pkg::SYM_OPEN;
			6: return sre_pkg::SYM_CLOSE;
			default: return sre_pkg::SYM_SPACE;
		endcase
	endfunction

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_request(c, last);
		if (c != sre_pkg::SYM_SPACE)
			n_sent++;
	endtask

	task automatic send_text(input string s, input logic last);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], last && (i == s.len() - 1));
	endtask

	task automatic send_expr_chars(input logic last);
		for (int i = 0; i < expr_chars.size(); i++)
			send_char(expr_chars[i], last && (i == expr_chars.size() - 1));
	endtask

	// Result side: random stalls plus one long hold-off while requests keep coming.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		hold_done  = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!hold_done && sb.n_req >= 200) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1;
			end
			if (no_idle) begin
				m_tready <= 1'b1;
			end else begin
				if (stall_left == 0)
					stall_left = pick_gap();
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_status(m_tdata);
	end

	initial begin
		#8_000_000;
		$display("timeout: %0d requests, %0d results", sb.n_req, sb.n_res);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int r;
		bit last;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		no_idle  = 0;
		n_sent   = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reductions, spaces, split id, empty stack, byte extremes
		send_text("id", 1'b1);
		send_text("id+id*id", 1'b1);
		send_text("( id )", 1'b1);
		send_text(" ", 1'b1);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		send_text("E", 1'b1);
		send_text("i d)", 1'b1);

		n_sent = 0;
		while (n_sent < RAND_CHARS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			last    = ($urandom_range(0, 9) != 0);
			expr_chars.delete();
			r = $urandom_range(0, 99);
			if (r < 70) begin
				gen_expr($urandom_range(0, 4));
				// broken sequence: corrupt or drop one character
				if (r >= 58) begin
					int pos;
					pos = $urandom_range(0, expr_chars.size() - 1);
					if (r < 64)
						expr_chars[pos] = 8'($urandom_range(0, 255));
					else
						expr_chars.delete(pos);
				end
			end else if (r < 85) begin
				repeat ($urandom_range(1, 12))
					expr_chars.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 20))
					expr_chars.push_back(token_char());
			end
			send_expr_chars(last);
		end

		// fill the stack to the top, then push into a full stack
		no_idle = 0;
		repeat (sre_pkg::STACK_DEPTH) send_char(sre_pkg::SYM_I, 1'b0);
		send_char(sre_pkg::SYM_D, 1'b0);
		send_char(sre_pkg::SYM_I, 1'b1);
		send_text("id", 1'b1);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests, %0d results, %0d with a single E on the stack",
			sb.n_req, sb.n_res, sb.n_accepted);
		$display("deepest stack %0d of %0d, overflow flag %0b at the end",
			sb.max_depth, sre_pkg::STACK_DEPTH, sb.ovf);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
